// ===== sv/tlsf_pkg.sv =====
// shared types, constants and helpers for the luma stretch fill block
// no dependencies
package tlsf_pkg;

  localparam int HIST_BINS = 64;
  localparam int BIN_W     = 6;
  localparam int CNT_W     = 17;
  localparam logic [CNT_W-1:0] MAX_PIXELS = 17'd65536;

  localparam logic [23:0] LUMA_W_R  = 24'd13933;
  localparam logic [23:0] LUMA_W_G  = 24'd46871;
  localparam logic [23:0] LUMA_W_B  = 24'd4732;
  localparam logic [23:0] LUMA_FULL = 24'd16711680;

  localparam logic [1:0] MODE_INK  = 2'd0;
  localparam logic [1:0] MODE_FLAT = 2'd1;
  localparam logic [1:0] MODE_PASS = 2'd2;

  localparam logic [7:0] CFG_FILL_RED   = 8'd0;
  localparam logic [7:0] CFG_FILL_GREEN = 8'd1;
  localparam logic [7:0] CFG_FILL_BLUE  = 8'd2;
  localparam logic [7:0] CFG_FILL_ALPHA = 8'd3;

  typedef struct packed {
    logic             rd_en;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             clr;
  } hist_req_t;

  // floor(x / 255) by reciprocal with one correction step
  function automatic logic [9:0] div255(input logic [16:0] x);
    logic [25:0] p;
    logic [9:0]  est;
    logic [17:0] rem;
    p   = 26'(x) * 26'd257;
    est = p[25:16];
    rem = 18'(x) - 18'(est) * 18'd255;
    if (rem >= 18'd255) begin
      est = est + 10'd1;
    end
    return est;
  endfunction

endpackage

// ===== sv/template_luma_stretch_fill.sv =====
// top level: two-pass luminance stencil recolour of an icon
// uses tlsf_pkg, tlsf_hist (histogram store) and tlsf_div (ink divider)
//
//  channel | handshake            | request
//  in_     | in_valid / in_stall  | one pixel, sample or apply pass
//  out_    | out_valid / out_stall| one premultiplied result pixel
//  cfg_    | cfg_valid / cfg_ready| fill colour register write
//
// one pixel at a time; a counted sample pixel does a histogram read-modify-write
// the last sample pixel adds a percentile sweep over the 64 histogram bins if any were counted
// apply pixels: pass-through, flat (S_FLAT) or stretched (ink states, 16-step divider)
// reset leaves the histogram empty through per-bin valid bits, no clearing pass
// a finished result waits in the output register while the next pixel is taken in
module template_luma_stretch_fill (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_pix_red,
  input  logic [7:0] in_pix_green,
  input  logic [7:0] in_pix_blue,
  input  logic [7:0] in_pix_alpha,
  input  logic       in_last_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic [1:0] out_fill_mode,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tlsf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LUMA, S_BIN, S_RMW, S_SRCH, S_MODE, S_INK0, S_INK1, S_DIV,
    S_SHP0, S_SHP1, S_SHP2, S_ALP0, S_ALP1, S_ALP2, S_FLAT, S_COLR, S_PUT
  } state_t;

  state_t           state_r;
  logic [7:0]       fr_r, fg_r, fb_r, fa_r;
  logic             req_r, last_r;
  logic [7:0]       r_r, g_r, b_r, a_r;
  logic [23:0]      luma_r;
  logic [CNT_W-1:0] count_r;
  logic [BIN_W-1:0] low_r, high_r, bin_r, lo_c_r, hi_c_r, rd_bin_r;
  logic             lo_f_r, hi_f_r, rd_pend_r;
  logic [BIN_W:0]   issue_r;
  logic [CNT_W-1:0] seen_r;
  logic [1:0]       mode_r;
  logic [30:0]      a128_r, base_r, den_r;
  logic [14:0]      dp_r;
  logic [16:0]      ink_r, t_r, t2_r, s_r;
  logic [24:0]      as_r;
  logic [32:0]      x_r;
  logic [7:0]       oa_r, cr_r, cg_r, cb_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [1:0]       out_fill_mode_r;

  hist_req_t        hreq;
  logic [CNT_W-1:0] hdata;
  logic             div_start, div_done;
  logic [15:0]      div_quo;
  logic [30:0]      div_num;

  logic [9:0]       bin_q;
  logic [BIN_W-1:0] bin_c;
  logic             cnt_ok;
  logic [CNT_W-1:0] seen_nxt;
  logic [23:0]      s100;
  logic [BIN_W-1:0] dlt;
  logic [30:0]      num_w;
  logic             light;
  logic [7:0]       mx, mn;
  logic [16:0]      inkv;
  logic [22:0]      p100;
  logic [16:0]      tt;
  logic [17:0]      fct;
  logic [9:0]       aq;
  logic [7:0]       sr, sg, sb;
  logic             out_free;

  tlsf_hist u_hist (.clk(clk), .rst_n(rst_n), .req(hreq), .rd_data(hdata));

  tlsf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(dp_r),
    .done(div_done), .quo(div_quo)
  );

  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    bin_q    = div255(17'(luma_r >> 10));
    bin_c    = bin_q > 10'(HIST_BINS - 1) ? BIN_W'(HIST_BINS - 1) : bin_q[BIN_W-1:0];
    cnt_ok   = a_r >= 8'd128 && count_r < MAX_PIXELS;
    seen_nxt = seen_r + hdata;
    s100     = 24'(seen_nxt) * 24'd100;
    dlt      = high_r - low_r;
    num_w    = a128_r - base_r;
    mx       = fr_r;
    mn       = fr_r;
    if (fg_r > mx) mx = fg_r;
    if (fg_r < mn) mn = fg_r;
    if (fb_r > mx) mx = fb_r;
    if (fb_r < mn) mn = fb_r;
    light    = (9'(mx) + 9'(mn)) > 9'd255;
    inkv     = light ? ink_r : 17'd65536 - ink_r;
    p100     = 23'(inkv) * 23'd100;
    tt       = 17'((p100 - 23'd1179648) >> 6);
    fct      = 18'd196608 - {t_r, 1'b0};
    aq       = div255(17'(x_r >> 16));
    sr       = mode_r == MODE_PASS ? r_r : fr_r;
    sg       = mode_r == MODE_PASS ? g_r : fg_r;
    sb       = mode_r == MODE_PASS ? b_r : fb_r;
    div_num  = num_w;
    div_start = state_r == S_INK1 && a128_r > base_r && dlt != '0 && num_w < den_r;

    hreq         = '0;
    hreq.wr_en   = state_r == S_RMW;
    hreq.wr_addr = bin_r;
    hreq.wr_data = hdata + CNT_W'(1);
    hreq.clr     = state_r == S_PUT && out_free && last_r;
    if (state_r == S_BIN && cnt_ok) begin
      hreq.rd_en   = 1'b1;
      hreq.rd_addr = bin_c;
    end else if (state_r == S_SRCH && !issue_r[BIN_W]) begin
      hreq.rd_en   = 1'b1;
      hreq.rd_addr = issue_r[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILL_RED:   fr_r <= cfg_data;
        CFG_FILL_GREEN: fg_r <= cfg_data;
        CFG_FILL_BLUE:  fb_r <= cfg_data;
        CFG_FILL_ALPHA: fa_r <= cfg_data;
        default: ;
      endcase
    end
    if (!rst_n) begin
      fr_r <= 8'd255;
      fg_r <= 8'd255;
      fb_r <= 8'd255;
      fa_r <= 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      low_r       <= '0;
      high_r      <= '0;
      mode_r      <= MODE_PASS;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= state_r == S_SRCH && !issue_r[BIN_W];
      if (state_r == S_PUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_req_type;
            r_r     <= in_pix_red;
            g_r     <= in_pix_green;
            b_r     <= in_pix_blue;
            a_r     <= in_pix_alpha;
            last_r  <= in_last_pixel;
            state_r <= S_LUMA;
          end
        end
        S_LUMA: begin
          luma_r <= LUMA_W_R * 24'(r_r) + LUMA_W_G * 24'(g_r) + LUMA_W_B * 24'(b_r);
          oa_r   <= a_r;
          if (!req_r) begin
            state_r <= S_BIN;
          end else if (mode_r == MODE_INK) begin
            state_r <= S_INK0;
          end else if (mode_r == MODE_FLAT) begin
            state_r <= S_FLAT;
          end else begin
            state_r <= S_COLR;
          end
        end
        S_BIN: begin
          bin_r   <= bin_c;
          issue_r <= '0;
          seen_r  <= '0;
          lo_c_r  <= BIN_W'(HIST_BINS - 1);
          hi_c_r  <= BIN_W'(HIST_BINS - 1);
          lo_f_r  <= 1'b0;
          hi_f_r  <= 1'b0;
          if (cnt_ok) begin
            state_r <= S_RMW;
          end else if (!last_r) begin
            state_r <= S_IDLE;
          end else if (count_r == '0) begin
            state_r <= S_MODE;
          end else begin
            state_r <= S_SRCH;
          end
        end
        S_RMW: begin
          count_r <= count_r + CNT_W'(1);
          state_r <= last_r ? S_SRCH : S_IDLE;
        end
        S_SRCH: begin
          if (!issue_r[BIN_W]) begin
            issue_r <= issue_r + (BIN_W+1)'(1);
          end
          rd_bin_r <= issue_r[BIN_W-1:0];
          if (rd_pend_r) begin
            seen_r <= seen_nxt;
            if (!lo_f_r && s100 > 24'(count_r) * 24'd3) begin
              lo_c_r <= rd_bin_r;
              lo_f_r <= 1'b1;
            end
            if (!hi_f_r && s100 > 24'(count_r) * 24'd97) begin
              hi_c_r <= rd_bin_r;
              hi_f_r <= 1'b1;
            end
            if (rd_bin_r == BIN_W'(HIST_BINS - 1)) begin
              state_r <= S_MODE;
            end
          end
        end
        S_MODE: begin
          if (count_r == '0) begin
            mode_r <= MODE_PASS;
          end else begin
            low_r  <= lo_c_r;
            high_r <= hi_c_r;
            if (14'(hi_c_r - lo_c_r) * 14'd100 < 14'(12 * HIST_BINS)) begin
              mode_r <= MODE_FLAT;
            end else begin
              mode_r <= MODE_INK;
            end
          end
          state_r <= S_IDLE;
        end
        S_INK0: begin
          a128_r  <= 31'(luma_r) << 7;
          base_r  <= 31'({low_r, 1'b1}) * 31'(LUMA_FULL);
          den_r   <= 31'({dlt, 1'b0}) * 31'(LUMA_FULL);
          dp_r    <= 15'(dlt) * 15'd510;
          state_r <= S_INK1;
        end
        S_INK1: begin
          if (a128_r <= base_r || dlt == '0) begin
            ink_r   <= '0;
            state_r <= S_SHP0;
          end else if (num_w >= den_r) begin
            ink_r   <= 17'd65536;
            state_r <= S_SHP0;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ink_r   <= {1'b0, div_quo};
            state_r <= S_SHP0;
          end
        end
        S_SHP0: begin
          if (p100 <= 23'd1179648) begin
            t_r <= '0;
          end else begin
            t_r <= tt > 17'd65536 ? 17'd65536 : tt;
          end
          state_r <= S_SHP1;
        end
        S_SHP1: begin
          t2_r    <= 17'((34'(t_r) * 34'(t_r)) >> 16);
          state_r <= S_SHP2;
        end
        S_SHP2: begin
          s_r     <= 17'((35'(t2_r) * 35'(fct)) >> 16);
          state_r <= S_ALP0;
        end
        S_ALP0: begin
          as_r    <= 25'(a_r) * 25'(s_r);
          state_r <= S_ALP1;
        end
        S_ALP1: begin
          x_r     <= 33'(as_r) * 33'(fa_r) + 33'(LUMA_FULL >> 1);
          state_r <= S_ALP2;
        end
        S_ALP2: begin
          if (a_r == 8'd0 || aq < 10'd10) begin
            oa_r <= '0;
          end else if (aq > 10'd255) begin
            oa_r <= 8'd255;
          end else begin
            oa_r <= aq[7:0];
          end
          state_r <= S_COLR;
        end
        S_FLAT: begin
          oa_r    <= 8'(div255(17'(16'(a_r) * 16'(fa_r)) + 17'd127));
          state_r <= S_COLR;
        end
        S_COLR: begin
          cr_r    <= 8'(div255(17'(16'(sr) * 16'(oa_r)) + 17'd127));
          cg_r    <= 8'(div255(17'(16'(sg) * 16'(oa_r)) + 17'd127));
          cb_r    <= 8'(div255(17'(16'(sb) * 16'(oa_r)) + 17'd127));
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_red_r       <= cr_r;
            out_green_r     <= cg_r;
            out_blue_r      <= cb_r;
            out_alpha_r     <= oa_r;
            out_fill_mode_r <= mode_r;
            out_last_r      <= last_r;
            if (last_r) begin
              count_r <= '0;
              mode_r  <= MODE_PASS;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha     = out_alpha_r;
  assign out_fill_mode = out_fill_mode_r;
  assign out_last      = out_last_r;

`ifndef ASSERT_OFF
  a_no_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(hreq.wr_en && hreq.clr)) else $error("histogram write during clear");
  a_ink_span: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_INK |-> (high_r - low_r) >= BIN_W'(8)) else $error("ink mode with narrow span");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_PIXELS) else $error("sample count beyond cap");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider finished outside its wait");
`endif

endmodule

// ===== sv/tlsf_hist.sv =====
// luminance histogram store, one read and one write port, registered read
// entries not yet written since the last clear read as zero; uses tlsf_pkg
module tlsf_hist (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlsf_pkg::hist_req_t            req,
  output logic [tlsf_pkg::CNT_W-1:0]     rd_data
);
  import tlsf_pkg::*;

  logic [CNT_W-1:0]     mem [HIST_BINS];
  logic [HIST_BINS-1:0] vld_r;
  logic [CNT_W-1:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/tlsf_div.sv =====
// serial restoring divider, one quotient bit per cycle, 16 bits
// numerator below den * 2^16; uses no package
module tlsf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [14:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic [15:0] rem_r;
  logic [15:0] low_r;
  logic [15:0] quo_r;
  logic [14:0] den_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] r2;
  logic        ge;

  assign r2 = {rem_r, low_r[15]};
  assign ge = r2 >= {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[30:16] == 15'd0 ? 16'd0 : {1'b0, num[30:16]};
      low_r <= num[15:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? 16'(r2 - {2'b0, den_r}) : r2[15:0];
      low_r <= {low_r[14:0], 1'b0};
      quo_r <= {quo_r[14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
